FILE: design/stbs_pkg.sv
// Shared types and constants for the sorted-table binary search block.
// No dependencies; imported by stbs_search and the top level in the design folder.
`default_nettype none

package stbs_pkg;

  localparam int unsigned TableDepth = 1024;
  localparam int unsigned ValueWidth = 32;
  localparam int unsigned IdxW       = $clog2(TableDepth);
  localparam int unsigned CountW     = IdxW + 1;

  typedef enum logic {
    FuncLoad   = 1'b0,
    FuncSearch = 1'b1
  } func_e;

  typedef struct packed {
    func_e                        func;
    logic [IdxW-1:0]              entry_index;
    logic signed [ValueWidth-1:0] data_value;
  } in_req_t;

  typedef struct packed {
    logic            found;
    logic [IdxW-1:0] position;
  } out_rsp_t;

  // search handshake between sequencer and top level
  typedef struct packed {
    logic busy;
    logic res_valid;
  } srch_stat_t;

  typedef enum logic [1:0] {
    StIdle,
    StProbe,
    StCmp,
    StDone
  } srch_state_e;

endpackage

`default_nettype wire

FILE: design/stbs_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module stbs_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

FILE: design/stbs_search.sv
// Binary search sequencer: issues one table read per probe and narrows the
// [left, hi) window on the registered read data. Depends on stbs_pkg.
`default_nettype none

module stbs_search import stbs_pkg::*; (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic signed [ValueWidth-1:0] key_i,
  input  wire logic [CountW-1:0]            count_i,
  output logic [IdxW-1:0]                   ram_raddr_o,
  input  wire logic signed [ValueWidth-1:0] ram_rdata_i,
  input  wire logic                         res_ready_i,
  output srch_stat_t                        stat_o,
  output out_rsp_t                          res_o
);

  srch_state_e state_q, state_d;

  logic signed [ValueWidth-1:0] key_q, key_d;
  logic [CountW-1:0]            left_q, left_d;
  logic [CountW-1:0]            hi_q, hi_d;
  logic [IdxW-1:0]              mid_q, mid_d;
  logic                         found_q, found_d;
  logic [IdxW-1:0]              pos_q, pos_d;

  logic [CountW:0]   mid_sum;
  logic [IdxW-1:0]   mid_w;
  logic              win_open;

  // window is [left, hi); midpoint equals (left + right) / 2 with right = hi - 1
  assign mid_sum  = {1'b0, left_q} + {1'b0, hi_q} - {{CountW{1'b0}}, 1'b1};
  assign mid_w    = mid_sum[IdxW:1];
  assign win_open = left_q < hi_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:  if (start_i) state_d = StProbe;
      StProbe: state_d = win_open ? StCmp : StDone;
      StCmp:   if (ram_rdata_i == key_q) begin
        state_d = StDone;
      end else begin
        state_d = StProbe;
      end
      StDone:  if (res_ready_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // outputs
  always_comb begin
    stat_o.busy      = state_q != StIdle;
    stat_o.res_valid = state_q == StDone;
    res_o.found      = found_q;
    res_o.position   = pos_q;
    ram_raddr_o      = mid_w;
  end

  // datapath
  always_comb begin
    key_d   = key_q;
    left_d  = left_q;
    hi_d    = hi_q;
    mid_d   = mid_q;
    found_d = found_q;
    pos_d   = pos_q;
    case (state_q)
      StIdle: begin
        key_d   = key_i;
        left_d  = '0;
        hi_d    = count_i;
        found_d = 1'b0;
        pos_d   = '0;
      end
      StProbe: mid_d = mid_w;
      StCmp: begin
        if (ram_rdata_i == key_q) begin
          found_d = 1'b1;
          pos_d   = mid_q;
        end else if (ram_rdata_i > key_q) begin
          hi_d = {1'b0, mid_q};
        end else begin
          left_d = {1'b0, mid_q} + {{IdxW{1'b0}}, 1'b1};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    left_q  <= left_d;
    hi_q    <= hi_d;
    mid_q   <= mid_d;
    found_q <= found_d;
    pos_q   <= pos_d;
  end

  // window never inverts during a search
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> (left_q <= hi_q))
    else $error("search window inverted");

  // probed index lies inside the live window
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StCmp) |-> (({1'b0, mid_q} >= left_q) && ({1'b0, mid_q} < hi_q)))
    else $error("probe outside window");

  // a miss reports position zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDone && !found_q) |-> (pos_q == '0))
    else $error("miss with nonzero position");

  // a miss is only declared once the window has closed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StProbe && !win_open) |=> (state_q == StDone && !found_q))
    else $error("closed window did not end search");

endmodule

`default_nettype wire

FILE: design/sorted_table_binary_search.sv
// Sorted-table binary search: a load is written straight into the table. Each search
// probe is a registered table read, then a compare, at most 11 probes for a full
// table. No new request is taken until the search result has been handed to the
// output register: one search at a time.
// Reset clears element_count and the control state; table contents are not
// cleared and are undefined until written.
`default_nettype none

module sorted_table_binary_search import stbs_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // request channel
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire in_req_t           in_data_i,
  // result channel
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output out_rsp_t               out_data_o,
  // element_count register
  input  wire logic              cfg_we_i,
  input  wire logic [CountW-1:0] cfg_data_i
);

  logic [CountW-1:0] count_q, count_d;
  logic              out_valid_q, out_valid_d;
  out_rsp_t          out_data_q, out_data_d;

  logic              in_acc;
  logic              load_we;
  logic              search_start;
  logic              res_ready;

  logic [IdxW-1:0]              ram_raddr;
  logic [ValueWidth-1:0]        ram_rdata;
  srch_stat_t                   stat;
  out_rsp_t                     res;

  // one request in flight; stalled while the sequencer is busy
  assign in_stall_o   = stat.busy;
  assign in_acc       = in_valid_i && !in_stall_o;
  assign load_we      = in_acc && (in_data_i.func == FuncLoad);
  assign search_start = in_acc && (in_data_i.func == FuncSearch);

  // output register frees when empty or being taken
  assign res_ready = !out_valid_q || !out_stall_i;

  // count saturates at the table depth when written
  always_comb begin
    count_d = count_q;
    if (cfg_we_i) begin
      count_d = (cfg_data_i > CountW'(TableDepth)) ? CountW'(TableDepth) : cfg_data_i;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (stat.res_valid && res_ready) begin
      out_valid_d = 1'b1;
      out_data_d  = res;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // table store: loads write directly, the sequencer owns the read port
  stbs_ram #(
    .Width (ValueWidth),
    .Depth (TableDepth)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (load_we),
    .waddr_i (in_data_i.entry_index),
    .wdata_i (in_data_i.data_value),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  stbs_search u_search (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (search_start),
    .key_i       (in_data_i.data_value),
    .count_i     (count_q),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .res_ready_i (res_ready),
    .stat_o      (stat),
    .res_o       (res)
  );

  // count never exceeds the table depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountW'(TableDepth))
    else $error("element count above depth");

  // a finished search is handed over whenever the output register is free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stat.res_valid && res_ready) |=> (out_valid_q && !stat.busy))
    else $error("result handover lost");

  // no request is taken while a search result is still held by the sequencer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.res_valid |-> in_stall_o)
    else $error("request accepted during search");

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// Self-checking bench for sorted_table_binary_search: table loads, searches and
// element_count settings, checked against a binary-search model of the table.
// Depends on stbs_pkg and the top level in the design folder.
`default_nettype none

module testbench;
  import stbs_pkg::*;

  localparam logic signed [ValueWidth-1:0] ValMin = {1'b1, {(ValueWidth-1){1'b0}}};
  localparam logic signed [ValueWidth-1:0] ValMax = ~ValMin;
  localparam int TargetRequests = 1550;
  localparam int CalmFrom       = 1380;  // no idling beyond this many requests
  localparam int SettleCycles   = 30;
  localparam int LongHold       = 300;

  // one line of the directed list: either a count setting or a request
  typedef struct {
    bit                cfg_row;
    logic [CountW-1:0] count;
    in_req_t           req;
    bit                typed;
    out_rsp_t          exp;
  } dir_row_t;

  logic              clk_i;
  logic              rst_ni    = 1'b0;
  logic              in_valid  = 1'b0;
  in_req_t           in_data   = '0;
  logic              out_stall = 1'b0;
  logic              cfg_we    = 1'b0;
  logic [CountW-1:0] cfg_data  = '0;
  logic              in_stall;
  logic              out_valid;
  out_rsp_t          out_data;

  // shadow of the block: table contents, which entries hold data, count in force
  logic signed [ValueWidth-1:0] shadow_table [TableDepth];
  bit                           written      [TableDepth];
  logic [CountW-1:0]            table_count = '0;
  out_rsp_t                     pending_results [$];

  bit idle_on        = 1'b0;
  int hold_cycles_req = 0;
  int errors         = 0;
  int sent           = 0;
  int searches       = 0;
  int results_seen   = 0;
  int settings       = 0;

  sorted_table_binary_search dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  task automatic flag_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch: %s: got %0d, want %0d", $time, what, got, want);
    errors++;
  endtask

  // Binary search over the shadow table, midpoint rounded down; the first
  // probe that matches wins. Count above the depth saturates.
  function automatic out_rsp_t search_table(input logic signed [ValueWidth-1:0] key);
    int       lo;
    int       hi;
    int       mid;
    int       span;
    out_rsp_t r;
    r    = '0;
    span = (int'(table_count) > TableDepth) ? TableDepth : int'(table_count);
    lo   = 0;
    hi   = span - 1;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      if (shadow_table[mid] == key) begin
        r.found    = 1'b1;
        r.position = mid[IdxW-1:0];
        return r;
      end else if (shadow_table[mid] > key) begin
        hi = mid - 1;
      end else begin
        lo = mid + 1;
      end
    end
    return r;
  endfunction

  // Offer one request, with an optional gap first; returns at the accepting edge,
  // where the shadow is brought up to date.
  task automatic send_req(input in_req_t r, input bit typed, input out_rsp_t typed_exp);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    @(posedge clk_i);
    while (in_stall !== 1'b0) @(posedge clk_i);
    sent++;
    if (r.func == FuncLoad) begin
      shadow_table[r.entry_index] = r.data_value;
      written[r.entry_index]      = 1'b1;
    end else begin
      searches++;
      pending_results.push_back(typed ? typed_exp : search_table(r.data_value));
    end
  endtask

  // Stop offering, let every pending search report, then let the block settle.
  task automatic wait_results_done();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (pending_results.size() != 0 && guard < 20000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_count(input logic [CountW-1:0] v);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk_i);
    cfg_we      <= 1'b0;
    table_count  = v;
    settings++;
  endtask

  // Ascending fill of entries 0..n-1, with repeats now and then; a full table
  // is spread from the most negative value to the top, clamping there.
  task automatic load_sorted(input int n);
    longint  acc;
    in_req_t r;
    if (n > 64) acc = -64'sd2147483648 + longint'($urandom_range(0, 1000));
    else        acc = longint'($signed($urandom));
    for (int i = 0; i < n; i++) begin
      if (acc > 64'sd2147483647) acc = 64'sd2147483647;
      r.func        = FuncLoad;
      r.entry_index = i[IdxW-1:0];
      r.data_value  = acc[ValueWidth-1:0];
      send_req(r, 1'b0, '0);
      if ($urandom_range(0, 7) != 0) begin
        if (n > 64) acc += longint'($urandom_range(1, 8000000));
        else        acc += longint'($urandom_range(1, 1 << $urandom_range(0, 30)));
      end
    end
  endtask

  // Mostly keys that sit in the table or just beside one; some extremes and noise.
  function automatic logic signed [ValueWidth-1:0] pick_key(input int span);
    int                           sel;
    logic signed [ValueWidth-1:0] k;
    sel = $urandom_range(0, 9);
    if (span == 0 || sel >= 8) k = $urandom;
    else if (sel <= 3)         k = shadow_table[$urandom_range(0, span - 1)];
    else if (sel <= 5)         k = shadow_table[$urandom_range(0, span - 1)] +
                                   ($urandom_range(0, 1) ? 1 : -1);
    else if (sel == 6)         k = ValMin;
    else                       k = ValMax;
    return k;
  endfunction

  function automatic dir_row_t load_row(input int idx, input logic signed [ValueWidth-1:0] v);
    dir_row_t d;
    d.cfg_row           = 1'b0;
    d.count             = '0;
    d.req.func          = FuncLoad;
    d.req.entry_index   = idx[IdxW-1:0];
    d.req.data_value    = v;
    d.typed             = 1'b0;
    d.exp               = '0;
    return d;
  endfunction

  function automatic dir_row_t search_row(input logic signed [ValueWidth-1:0] key,
                                          input bit typed, input bit hit, input int pos);
    dir_row_t d;
    d.cfg_row          = 1'b0;
    d.count            = '0;
    d.req.func         = FuncSearch;
    d.req.entry_index  = '1;
    d.req.data_value   = key;
    d.typed            = typed;
    d.exp.found        = hit;
    d.exp.position     = pos[IdxW-1:0];
    return d;
  endfunction

  function automatic dir_row_t count_row(input int c);
    dir_row_t d;
    d.cfg_row = 1'b1;
    d.count   = c[CountW-1:0];
    d.req     = '0;
    d.typed   = 1'b0;
    d.exp     = '0;
    return d;
  endfunction

  // Result side: checks each accepted result against the oldest expectation and
  // drives stall - random bursts, plus a long hold-off when the stimulus asks.
  initial begin : result_side
    out_rsp_t want;
    bit       stall_n;
    int       burst_left;
    int       hold_left;
    burst_left = 0;
    hold_left  = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid === 1'b1 && !out_stall) begin
        if (pending_results.size() == 0) begin
          flag_mismatch("result with no search pending", 1, 0);
        end else begin
          want = pending_results.pop_front();
          results_seen++;
          if (out_data.found !== want.found)
            flag_mismatch("found", out_data.found, want.found);
          if (out_data.position !== want.position)
            flag_mismatch("position", out_data.position, want.position);
        end
      end
      if (hold_cycles_req != 0) begin
        hold_left       = hold_cycles_req;
        hold_cycles_req = 0;
      end
      if (hold_left > 0) begin
        stall_n = 1'b1;
        hold_left--;
      end else if (burst_left > 0) begin
        stall_n = 1'b1;
        burst_left--;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        stall_n    = 1'b1;
        burst_left = $urandom_range(0, 5);
      end else begin
        stall_n = 1'b0;
      end
      out_stall <= stall_n;
    end
  end

  initial begin : stimulus
    dir_row_t                 dir_rows [$];
    in_req_t                  r;
    logic [CountW-1:0]        cnt;
    int                       span;
    int                       n;
    bit                       prefix_ok;

    // Directed part. Only entries below the count in force are ever probed,
    // so every search here sees written entries.
    dir_rows.push_back(search_row(0, 1'b1, 1'b0, 0));       // empty table after reset
    dir_rows.push_back(search_row(ValMin, 1'b1, 1'b0, 0));
    dir_rows.push_back(load_row(0, ValMin));
    dir_rows.push_back(load_row(1, -1));
    dir_rows.push_back(load_row(2, 0));
    dir_rows.push_back(load_row(3, 1));
    dir_rows.push_back(load_row(4, ValMax));
    dir_rows.push_back(load_row(TableDepth - 1, 32'h5555_5555));
    dir_rows.push_back(load_row(682, 32'h2AAA_AAAA));
    dir_rows.push_back(count_row(5));
    dir_rows.push_back(search_row(ValMin, 1'b1, 1'b1, 0));
    dir_rows.push_back(search_row(0, 1'b1, 1'b1, 2));       // first probe hits
    dir_rows.push_back(search_row(ValMax, 1'b1, 1'b1, 4));
    dir_rows.push_back(search_row(-1, 1'b0, 1'b0, 0));
    dir_rows.push_back(search_row(1, 1'b0, 1'b0, 0));
    dir_rows.push_back(search_row(2, 1'b0, 1'b0, 0));       // falls between entries
    dir_rows.push_back(search_row(-2, 1'b0, 1'b0, 0));
    dir_rows.push_back(count_row(1));
    dir_rows.push_back(search_row(ValMin, 1'b1, 1'b1, 0));
    dir_rows.push_back(search_row(ValMax, 1'b1, 1'b0, 0));  // present, but past the count
    dir_rows.push_back(count_row(0));
    dir_rows.push_back(search_row(ValMin, 1'b1, 1'b0, 0));  // empty table again
    dir_rows.push_back(load_row(2, ValMin));                // table no longer ascending
    dir_rows.push_back(count_row(5));
    dir_rows.push_back(search_row(ValMin, 1'b0, 1'b0, 0));
    dir_rows.push_back(search_row(ValMax, 1'b0, 1'b0, 0));

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    idle_on = 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].cfg_row) begin
        wait_results_done();
        set_count(dir_rows[i].count);
      end else begin
        send_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].exp);
      end
    end
    wait_results_done();

    // Random part, one count setting per phase. The first few phases use short
    // tables, the fifth fills the whole table and sets the count past the depth;
    // after that any count is safe to search.
    for (int p = 0; sent < TargetRequests; p++) begin
      if (sent > CalmFrom) idle_on = 1'b0;
      else                 idle_on = ($urandom_range(0, 3) != 0);

      if (p < 2)       cnt = CountW'(p + 1);
      else if (p < 4)  cnt = CountW'($urandom_range(3, 40));
      else if (p == 4) cnt = '1;
      else begin
        case ($urandom_range(0, 7))
          0:       cnt = '0;
          1:       cnt = CountW'(TableDepth);
          2:       cnt = CountW'(TableDepth - 1);
          3:       cnt = CountW'($urandom_range(TableDepth + 1, 2046));
          4:       cnt = '1;
          5:       cnt = CountW'($urandom_range(1, 3));
          default: cnt = CountW'($urandom_range(1, TableDepth));
        endcase
      end
      span = (int'(cnt) > TableDepth) ? TableDepth : int'(cnt);

      prefix_ok = 1'b1;
      for (int i = 0; i < span; i++) if (!written[i]) prefix_ok = 1'b0;
      if (!prefix_ok || (span <= 64 && $urandom_range(0, 1) != 0)) load_sorted(span);
      wait_results_done();
      set_count(cnt);

      // block fills up behind a stalled result while requests keep coming
      if (p == 2 || p == 7) begin
        idle_on         = 1'b0;
        hold_cycles_req = LongHold;
      end

      n = $urandom_range(20, 60);
      repeat (n) begin
        if ($urandom_range(0, 9) == 0) begin
          r.func        = FuncLoad;
          r.entry_index = IdxW'($urandom_range(0, TableDepth - 1));
          r.data_value  = $urandom;
        end else begin
          r.func        = FuncSearch;
          r.entry_index = IdxW'($urandom);
          r.data_value  = pick_key(span);
        end
        send_req(r, 1'b0, '0);
      end
      wait_results_done();
    end

    if (pending_results.size() != 0)
      flag_mismatch("searches left without a result", pending_results.size(), 0);
    $display("Covered %0d requests (%0d searches, %0d results checked) over %0d count settings,",
             sent, searches, results_seen, settings);
    $display("from an empty table to a full one with the count past the depth.");
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #1000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

`default_nettype wire
